// ----- src/kruskal_mst_union_find_top_defines.svh -----
// assertion macros for the kruskal union-find block
`ifndef KRUSKAL_MST_UNION_FIND_TOP_DEFINES_SVH
`define KRUSKAL_MST_UNION_FIND_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KMST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kmst check failed");

// next-cycle implication, disabled during reset
`define KMST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kmst check failed");

`endif

// ----- src/kmst_pkg.sv -----
// shared types and constants of the kruskal union-find block
`default_nettype none

package kmst_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int CFG_W         = 11;
	localparam int END_W         = 10;
	localparam int WEIGHT_W      = 32;
	localparam int COST_W        = 64;
	localparam int IN_DATA_W     = 56;
	localparam int OUT_DATA_W    = 64;

	localparam logic [CFG_W-1:0] NODE_COUNT_RST = 11'd1024;

	// one input item
	typedef struct packed {
		logic [WEIGHT_W-1:0] edge_weight;
		logic [END_W-1:0]    end_a;
		logic [END_W-1:0]    end_b;
		logic                last_edge;
	} kmst_edge_t;

	// one result item
	typedef struct packed {
		logic              accepted;
		logic [COST_W-1:0] total_cost;
		logic              done_res;
	} kmst_res_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_FIND_P,
		ST_FIND_G,
		ST_SIZE_A,
		ST_SIZE_B,
		ST_RESULT
	} kmst_st_t;

endpackage

`default_nettype wire

// ----- src/kmst_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module kmst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- src/kmst_engine.sv -----
// union-find sequencer: path-halving finds, union by size, clearing pass
`default_nettype none

module kmst_engine #(
	parameter int MAX_NODES = kmst_pkg::MAX_NODES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [kmst_pkg::CFG_W-1:0]  node_count,
	input  wire logic                        in_valid,
	input  wire kmst_pkg::kmst_edge_t        in_edge,
	output logic                             in_ready,
	input  wire logic                        slot_free,
	output logic                             res_valid,
	output kmst_pkg::kmst_res_t              res
);

	import kmst_pkg::*;

	localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int SW = $clog2(MAX_NODES + 1);
	localparam int EW = (NW > END_W) ? NW : END_W;
	localparam int CW = (SW > CFG_W) ? SW : CFG_W;

	kmst_st_t state_q, state_d;

	// control state
	logic [COST_W-1:0] cost_q;
	logic [NW-1:0]     joined_q;
	logic              complete_q;
	logic [NW-1:0]     clr_q;

	// item payload and walk registers
	logic [WEIGHT_W-1:0] weight_q;
	logic [NW-1:0]       a_q, b_q, v_q, ra_q, rb_q;
	logic                rng_ok_q, last_q, phase_q, acc_q;
	logic [SW-1:0]       sa_q;

	// memory ports
	logic          p_we, s_we;
	logic [NW-1:0] p_waddr, p_raddr, s_waddr, s_raddr;
	logic [NW-1:0] p_wdata, p_rdata;
	logic [SW-1:0] s_wdata, s_rdata;

	logic [CW-1:0] nc_ext, max_ext, eff_nodes;
	logic [EW-1:0] ea_ext, eb_ext;
	logic          accept, p_root, size_a_wins;
	logic [CW-1:0] joined_next_ext;

	kmst_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_parent (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	kmst_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_size (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// effective node count, clamped to one .. MAX_NODES
	always_comb begin
		nc_ext  = CW'(node_count);
		max_ext = CW'(MAX_NODES);
		if (nc_ext == '0) begin
			eff_nodes = CW'(1);
		end else if (nc_ext > max_ext) begin
			eff_nodes = max_ext;
		end else begin
			eff_nodes = nc_ext;
		end
	end

	assign ea_ext          = EW'(in_edge.end_a);
	assign eb_ext          = EW'(in_edge.end_b);
	assign accept          = in_valid && in_ready;
	assign p_root          = (p_rdata == v_q);
	assign size_a_wins     = (sa_q > s_rdata);
	assign joined_next_ext = CW'(joined_q) + CW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == NW'(MAX_NODES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_START;
			end
			ST_START: begin
				if (complete_q || !rng_ok_q) state_d = ST_RESULT;
				else state_d = ST_FIND_P;
			end
			ST_FIND_P: begin
				if (!p_root) begin
					state_d = ST_FIND_G;
				end else if (phase_q) begin
					state_d = (v_q != ra_q) ? ST_SIZE_A : ST_RESULT;
				end
			end
			ST_FIND_G: state_d = ST_FIND_P;
			ST_SIZE_A: state_d = ST_SIZE_B;
			ST_SIZE_B: state_d = ST_RESULT;
			ST_RESULT: begin
				if (slot_free) state_d = last_q ? ST_CLEAR : ST_IDLE;
			end
			default:   state_d = ST_CLEAR;
		endcase
	end

	// memory ports and handshake outputs
	always_comb begin
		p_we      = 1'b0;
		p_waddr   = v_q;
		p_wdata   = p_rdata;
		p_raddr   = a_q;
		s_we      = 1'b0;
		s_waddr   = ra_q;
		s_wdata   = sa_q + s_rdata;
		s_raddr   = ra_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				p_we    = 1'b1;
				p_waddr = clr_q;
				p_wdata = clr_q;
				s_we    = 1'b1;
				s_waddr = clr_q;
				s_wdata = SW'(1);
			end
			ST_IDLE:   in_ready = 1'b1;
			ST_START:  p_raddr = a_q;
			ST_FIND_P: begin
				// root of end_a found: start on end_b, else fetch grandparent
				if (p_root) p_raddr = b_q;
				else p_raddr = p_rdata;
				s_raddr = ra_q;
			end
			ST_FIND_G: begin
				// path halving: point v at its grandparent and step there
				p_we    = 1'b1;
				p_waddr = v_q;
				p_wdata = p_rdata;
				p_raddr = p_rdata;
			end
			ST_SIZE_A: s_raddr = rb_q;
			ST_SIZE_B: begin
				// union by size, second root wins a tie
				p_we = 1'b1;
				s_we = 1'b1;
				if (size_a_wins) begin
					p_waddr = rb_q;
					p_wdata = ra_q;
					s_waddr = ra_q;
				end else begin
					p_waddr = ra_q;
					p_wdata = rb_q;
					s_waddr = rb_q;
				end
			end
			ST_RESULT: res_valid = slot_free;
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cost_q     <= '0;
			joined_q   <= '0;
			complete_q <= 1'b0;
			clr_q      <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + NW'(1);
				ST_SIZE_B: begin
					cost_q   <= cost_q + {{(COST_W - WEIGHT_W){weight_q[WEIGHT_W-1]}}, weight_q};
					joined_q <= joined_q + NW'(1);
					if (joined_next_ext >= eff_nodes - CW'(1)) complete_q <= 1'b1;
				end
				ST_RESULT: begin
					if (slot_free && last_q) begin
						cost_q     <= '0;
						joined_q   <= '0;
						complete_q <= 1'b0;
						clr_q      <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// item payload and find walk
	always_ff @(posedge clk) begin
		if (accept) begin
			weight_q <= in_edge.edge_weight;
			last_q   <= in_edge.last_edge;
			a_q      <= ea_ext[NW-1:0];
			b_q      <= eb_ext[NW-1:0];
			rng_ok_q <= (CW'(in_edge.end_a) < eff_nodes) && (CW'(in_edge.end_b) < eff_nodes);
		end
		case (state_q)
			ST_START: begin
				acc_q   <= 1'b0;
				v_q     <= a_q;
				phase_q <= 1'b0;
			end
			ST_FIND_P: begin
				if (p_root) begin
					if (!phase_q) begin
						ra_q    <= v_q;
						v_q     <= b_q;
						phase_q <= 1'b1;
					end else begin
						rb_q <= v_q;
					end
				end
			end
			ST_FIND_G: v_q  <= p_rdata;
			ST_SIZE_A: sa_q <= s_rdata;
			ST_SIZE_B: acc_q <= 1'b1;
			default: begin
			end
		endcase
	end

	// result fields
	assign res.accepted   = acc_q;
	assign res.total_cost = cost_q;
	assign res.done_res   = complete_q || last_q;

endmodule

`default_nettype wire

// ----- src/kruskal_mst_union_find_top.sv -----
// Kruskal spanning-tree union-find block, top level.
//
// Edges sorted by ascending weight enter on the s_ stream, one item per edge;
// one result item per edge leaves on the m_ stream in the same order.
// node_count is set through cfg_we/cfg_wdata; the user must set it only while
// the block is idle, which the block itself does not enforce. Each edge in
// range, while the tree is not complete, runs two path-halving finds over the
// parent ram; only when the roots differ do a size lookup in the size ram and
// a union in both rams follow. A skipped edge (out of range or tree complete)
// runs no finds. The next edge can be taken in the cycle after the result is
// loaded, and the block works on one edge at a time.
// After reset, and after each edge marked last, a clearing pass writes
// every ram entry, one per cycle; s_tready stays low.
// A result waits in the output register while the receiver stalls; the
// next edge is still accepted and worked up to its own result.
`default_nettype none
`include "kruskal_mst_union_find_top_defines.svh"

module kruskal_mst_union_find_top #(
	parameter int MAX_NODES = kmst_pkg::MAX_NODES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [kmst_pkg::CFG_W-1:0]        cfg_wdata,  // node_count
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [kmst_pkg::IN_DATA_W-1:0]    s_tdata,    // edge_weight, end_a, end_b
	input  wire logic                              s_tlast,    // last_edge
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [kmst_pkg::OUT_DATA_W-1:0]   m_tdata,    // total_cost
	output logic      [0:0]                        m_tuser,    // accepted
	output logic                                   m_tlast     // done_res
);

	import kmst_pkg::*;

	logic [CFG_W-1:0] node_count_q;
	kmst_edge_t       in_edge;
	kmst_res_t        res, out_q;
	logic             res_valid, slot_free, out_valid_q;

	// node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// unpack the input item
	assign in_edge.edge_weight = s_tdata[WEIGHT_W-1:0];
	assign in_edge.end_a       = s_tdata[WEIGHT_W+END_W-1:WEIGHT_W];
	assign in_edge.end_b       = s_tdata[WEIGHT_W+2*END_W-1:WEIGHT_W+END_W];
	assign in_edge.last_edge   = s_tlast;

	kmst_engine #(.MAX_NODES(MAX_NODES)) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_count (node_count_q),
		.in_valid   (s_tvalid),
		.in_edge    (in_edge),
		.in_ready   (s_tready),
		.slot_free  (slot_free),
		.res_valid  (res_valid),
		.res        (res)
	);

	// output register
	assign slot_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_q.total_cost;
	assign m_tuser[0] = out_q.accepted;
	assign m_tlast    = out_q.done_res;

	// a new result never overwrites one still waiting
	`KMST_ASSERT_IMP(a_no_overwrite, clk, arst_n, res_valid, slot_free)
	// one item at a time inside the engine
	`KMST_ASSERT_NXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// a loaded result shows up on the output
	`KMST_ASSERT_NXT(a_result_shown, clk, arst_n, res_valid, m_tvalid)
	// the engine is busy while it hands over a result
	`KMST_ASSERT_IMP(a_busy_on_result, clk, arst_n, res_valid, !s_tready)

endmodule

`default_nettype wire
